### hdl/idm_pkg.sv
// ----------------------------------------------------------------------------
// idm_pkg
// Shared types for the 64-bit integer divide/modulo block: the request and
// response payloads and the sequencer states.
// ----------------------------------------------------------------------------
package idm_pkg;

  // Port field width, fixed by the interface
  localparam int unsigned FieldW = 64;

  // Division mode
  typedef enum logic {
    CMD_UNSIGNED = 1'b0,
    CMD_SIGNED   = 1'b1
  } idm_cmd_e;

  // Input transaction
  typedef struct packed {
    idm_cmd_e            command;
    logic [FieldW-1:0]   dividend;
    logic [FieldW-1:0]   divisor;
  } idm_req_t;

  // Output transaction
  typedef struct packed {
    logic [FieldW-1:0]   quotient;
    logic [FieldW-1:0]   remainder;
  } idm_rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_A,
    ST_ABS_B,
    ST_DIV,
    ST_FIX_R,
    ST_FIX_Q
  } idm_state_e;

endpackage

### hdl/int64_divide_modulo.sv
// ----------------------------------------------------------------------------
// int64_divide_modulo
// Restoring shift-and-subtract divider giving quotient and remainder, with
// unsigned or signed two's complement operands, built around one subtractor.
// ----------------------------------------------------------------------------
// Sequence: the magnitude states ST_ABS_A and ST_ABS_B, then one quotient bit
//   per cycle through the shared subtractor in ST_DIV (skipped when the divisor
//   is zero), then the sign fix-up states ST_FIX_R and ST_FIX_Q.
// Input: a new transaction is taken only in ST_IDLE, after the previous result is posted.
// Reset: asynchronous, active low; clears the sequencer and output valid.
module int64_divide_modulo #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  idm_pkg::idm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output idm_pkg::idm_rsp_t out_rsp_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam int unsigned SubW = DATA_WIDTH + 2;
  localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);

  idm_pkg::idm_state_e state_q, state_d;

  logic [W-1:0]    num_q, num_d;      // dividend magnitude, then quotient
  logic [W-1:0]    den_q, den_d;      // divisor magnitude
  logic [W-1:0]    rem_q, rem_d;      // partial remainder
  logic            signed_q, signed_d;
  logic            nega_q, nega_d;
  logic            negb_q, negb_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  idm_pkg::idm_rsp_t out_rsp_q, out_rsp_d;

  // Shared subtractor
  logic [W:0]      sub_a, sub_b;
  logic [SubW-1:0] sub_res;
  logic            sub_borrow;
  logic [W:0]      rem_shift;
  logic            in_fire, out_free, den_zero, b_neg;

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[SubW-1];
  assign rem_shift  = {rem_q, num_q[W-1]};
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign den_zero   = (den_q == '0);
  assign b_neg      = signed_q && den_q[W-1];

  assign in_ready_o  = (state_q == idm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      idm_pkg::ST_IDLE: begin
        if (in_fire) state_d = idm_pkg::ST_ABS_A;
      end
      idm_pkg::ST_ABS_A: state_d = idm_pkg::ST_ABS_B;
      idm_pkg::ST_ABS_B: begin
        state_d = den_zero ? idm_pkg::ST_FIX_R : idm_pkg::ST_DIV;
      end
      idm_pkg::ST_DIV: begin
        if (cnt_q == CntLast) state_d = idm_pkg::ST_FIX_R;
      end
      idm_pkg::ST_FIX_R: state_d = idm_pkg::ST_FIX_Q;
      idm_pkg::ST_FIX_Q: begin
        if (out_free) state_d = idm_pkg::ST_IDLE;
      end
      default: state_d = idm_pkg::ST_IDLE;
    endcase
  end

  // Shared subtractor operand select
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_q)
      idm_pkg::ST_ABS_A: sub_b = {1'b0, num_q};
      idm_pkg::ST_ABS_B: sub_b = {1'b0, den_q};
      idm_pkg::ST_DIV: begin
        sub_a = rem_shift;
        sub_b = {1'b0, den_q};
      end
      idm_pkg::ST_FIX_R: sub_b = {1'b0, rem_q};
      idm_pkg::ST_FIX_Q: sub_b = {1'b0, num_q};
      default: ;
    endcase
  end

  // Datapath control
  always_comb begin
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    signed_d    = signed_q;
    nega_d      = nega_q;
    negb_d      = negb_q;
    cnt_d       = cnt_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      idm_pkg::ST_IDLE: begin
        // Capture the operands
        if (in_fire) begin
          num_d    = in_req_i.dividend[W-1:0];
          den_d    = in_req_i.divisor[W-1:0];
          signed_d = (in_req_i.command == idm_pkg::CMD_SIGNED);
        end
      end
      idm_pkg::ST_ABS_A: begin
        // Take the dividend magnitude
        nega_d = signed_q && num_q[W-1];
        if (signed_q && num_q[W-1]) num_d = sub_res[W-1:0];
      end
      idm_pkg::ST_ABS_B: begin
        // Take the divisor magnitude, or settle the zero divisor case
        negb_d = b_neg;
        cnt_d  = '0;
        if (den_zero) begin
          rem_d = num_q;
          num_d = W'(num_q == '0);
        end else begin
          rem_d = '0;
          if (b_neg) den_d = sub_res[W-1:0];
        end
      end
      idm_pkg::ST_DIV: begin
        // One quotient bit: shift, trial subtract, restore on borrow
        rem_d = sub_borrow ? rem_shift[W-1:0] : sub_res[W-1:0];
        num_d = {num_q[W-2:0], !sub_borrow};
        cnt_d = cnt_q + 1'b1;
      end
      idm_pkg::ST_FIX_R: begin
        // Remainder takes the dividend sign
        if (nega_q) rem_d = sub_res[W-1:0];
      end
      idm_pkg::ST_FIX_Q: begin
        // Negate the quotient on differing signs and post the result
        if (out_free) begin
          out_rsp_d.quotient  = idm_pkg::FieldW'((nega_q != negb_q) ? sub_res[W-1:0]
                                                                     : num_q);
          out_rsp_d.remainder = idm_pkg::FieldW'(rem_q);
          out_valid_d         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    signed_q  <= signed_d;
    nega_q    <= nega_d;
    negb_q    <= negb_d;
    out_rsp_q <= out_rsp_d;
  end

  // Accepted transaction starts the magnitude step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == idm_pkg::ST_ABS_A))
    else $error("divider did not start after accept");

  // Division never runs against a zero divisor
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idm_pkg::ST_DIV) |-> !den_zero)
    else $error("division step with zero divisor");

  // Last quotient bit leads to the sign fix-up
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idm_pkg::ST_DIV && cnt_q == CntLast) |=> (state_q == idm_pkg::ST_FIX_R))
    else $error("division did not end after the last bit");

  // Posting a result raises valid and frees the input side
  a_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idm_pkg::ST_FIX_Q && out_free) |=> (out_valid_o && in_ready_o))
    else $error("result not posted");

endmodule
